[rtl/modexp_pkg.sv]
// Shared constants, codes and types of the modular exponentiation unit.
package modexp_pkg;

    localparam int WIDTH     = 32;
    localparam int CNT_W     = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

    typedef enum logic {
        MM_OP_MUL,
        MM_OP_RED
    } t_mm_op;

    typedef struct packed {
        logic   start;
        t_mm_op op;
    } t_mm_req;

endpackage

[rtl/modular_exponentiation_unit.sv]
// Top level of the modular exponentiation unit with its sequencer and registers.
//
// Each item raises the message to the configured exponent modulo the configured
// modulus by right-to-left square-and-multiply. The block takes an item when
// start is high and busy is low, and drops busy only when the result has been
// presented; the result is shown for one cycle with the valid strobe and must be
// taken then, as the receiver cannot stall it. A zero modulus gives the error
// flag and a zero result in the cycle after the item is taken. Otherwise the
// message is first reduced, and then every exponent bit up to the highest set
// one costs a decision step, a squaring and, on a one bit, a multiplication;
// each modular multiplication does one doubling for every bit of its second
// operand and one more addition for every set bit of it, because the
// multiplier shares a single modular adder that does one addition per cycle.
// An exponent of zero returns 1, which is not reduced against the modulus.
module modular_exponentiation_unit
    import modexp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [WIDTH-1:0]     i_message,
    output logic                 o_valid,
    output logic [WIDTH-1:0]     o_result,
    output logic                 o_error,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIDTH-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_BIT,
        S_MUL,
        S_SQR
    } t_state;

    t_state           r_state;
    logic [WIDTH-1:0] r_exp;
    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_e;
    logic [WIDTH-1:0] r_res;
    logic [WIDTH-1:0] r_pw;
    logic             r_mm_start;
    t_mm_op           r_mm_op;
    logic [WIDTH-1:0] r_mm_a;
    logic [WIDTH-1:0] r_mm_b;
    logic             r_valid;
    logic [WIDTH-1:0] r_result;
    logic             r_error;

    t_mm_req          mm_req;
    logic             mm_done;
    logic [WIDTH-1:0] mm_p;
    logic [WIDTH-1:0] res_red;

    assign mm_req.start = r_mm_start;
    assign mm_req.op    = r_mm_op;
    assign res_red      = (r_res >= r_mod) ? '0 : r_res;

    modexp_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .i_a     (r_mm_a),
        .i_b     (r_mm_b),
        .i_m     (r_mod),
        .o_done  (mm_done),
        .o_p     (mm_p)
    );

    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= WIDTH'(1);
            r_mod <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_EXPONENT: r_exp <= i_cfg_data;
                REG_MODULUS:  r_mod <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mm_start <= 1'b0;
            r_mm_op    <= MM_OP_MUL;
            r_valid    <= 1'b0;
        end else begin
            r_mm_start <= 1'b0;
            r_valid    <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (r_mod == '0) begin
                            r_valid  <= 1'b1;
                            r_result <= '0;
                            r_error  <= 1'b1;
                        end else begin
                            r_res      <= WIDTH'(1);
                            r_e        <= r_exp;
                            r_mm_b     <= i_message;
                            r_mm_op    <= MM_OP_RED;
                            r_mm_start <= 1'b1;
                            r_state    <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (mm_done) begin
                        r_pw    <= mm_p;
                        r_state <= S_BIT;
                    end
                end
                S_BIT: begin
                    if (r_e == '0) begin
                        r_valid  <= 1'b1;
                        r_result <= r_res;
                        r_error  <= 1'b0;
                        r_state  <= S_IDLE;
                    end else if (r_e[0]) begin
                        r_mm_a     <= res_red;
                        r_mm_b     <= r_pw;
                        r_mm_op    <= MM_OP_MUL;
                        r_mm_start <= 1'b1;
                        r_state    <= S_MUL;
                    end else begin
                        r_mm_a     <= r_pw;
                        r_mm_b     <= r_pw;
                        r_mm_op    <= MM_OP_MUL;
                        r_mm_start <= 1'b1;
                        r_state    <= S_SQR;
                    end
                end
                S_MUL: begin
                    if (mm_done) begin
                        r_res      <= mm_p;
                        r_mm_a     <= r_pw;
                        r_mm_b     <= r_pw;
                        r_mm_op    <= MM_OP_MUL;
                        r_mm_start <= 1'b1;
                        r_state    <= S_SQR;
                    end
                end
                S_SQR: begin
                    if (mm_done) begin
                        r_pw    <= mm_p;
                        r_e     <= r_e >> 1;
                        r_state <= S_BIT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_error  = r_error;

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_result == '0))
        else $error("error result carries a nonzero value");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_valid))
        else $error("accepted item was neither worked on nor answered");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobe raised while still busy");

endmodule

[rtl/modexp_addmod.sv]
// Shared modular adder: (x + y + carry) reduced once against the modulus.
module modexp_addmod
    import modexp_pkg::*;
(
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic             i_cin,
    input  logic [WIDTH-1:0] i_m,
    output logic [WIDTH-1:0] o_sum
);

    logic [WIDTH:0] sum;
    logic [WIDTH:0] diff;

    assign sum  = {1'b0, i_x} + {1'b0, i_y} + {{WIDTH{1'b0}}, i_cin};
    assign diff = sum - {1'b0, i_m};

    always_comb begin
        if (sum >= {1'b0, i_m}) begin
            o_sum = diff[WIDTH-1:0];
        end else begin
            o_sum = sum[WIDTH-1:0];
        end
    end

endmodule

[rtl/modexp_modmul.sv]
// Bit-serial modular multiplier and reducer built around one modular adder.
module modexp_modmul
    import modexp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mm_req          i_req,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_done,
    output logic [WIDTH-1:0] o_p
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DBL,
        S_ADD
    } t_state;

    t_state           r_state;
    t_mm_op           r_op;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [WIDTH-1:0] n_acc;
    logic [WIDTH-1:0] add_y;
    logic             add_cin;
    logic             last_bit;

    assign add_y    = (r_state == S_ADD) ? r_a : r_acc;
    assign add_cin  = (r_op == MM_OP_RED) && (r_state == S_DBL) && r_b[WIDTH-1];
    assign last_bit = (r_cnt == CNT_W'(WIDTH - 1));

    modexp_addmod u_addmod (
        .i_x   (r_acc),
        .i_y   (add_y),
        .i_cin (add_cin),
        .i_m   (i_m),
        .o_sum (n_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_op    <= MM_OP_MUL;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_op    <= i_req.op;
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DBL;
                    end
                end
                S_DBL: begin
                    r_acc <= n_acc;
                    if ((r_op == MM_OP_MUL) && r_b[WIDTH-1]) begin
                        r_state <= S_ADD;
                    end else begin
                        r_b   <= r_b << 1;
                        r_cnt <= r_cnt + 1'b1;
                        if (last_bit) begin
                            r_state <= S_IDLE;
                            r_done  <= 1'b1;
                        end
                    end
                end
                S_ADD: begin
                    r_acc <= n_acc;
                    r_b   <= r_b << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (last_bit) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= S_DBL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

[tb/tb_modular_exponentiation_unit.sv]
// Self-checking testbench of the modular exponentiation unit against a built-in predictor.
`timescale 1ns / 100ps

module tb_modular_exponentiation_unit;
    import modexp_pkg::*;

    localparam logic [1:0] CFG_KEEP = 2'b00;
    localparam logic [1:0] CFG_EXP  = 2'b01;
    localparam logic [1:0] CFG_MOD  = 2'b10;
    localparam logic [1:0] CFG_BOTH = 2'b11;

    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 15;
    localparam int DRAIN_LIMIT    = 20000;

    typedef struct {
        logic [WIDTH-1:0] result;
        logic             error;
    } t_power;

    typedef struct {
        logic [1:0]       cfg_mask;
        logic [WIDTH-1:0] exp_val;
        logic [WIDTH-1:0] mod_val;
        logic [WIDTH-1:0] msg;
        bit               known;
        logic [WIDTH-1:0] result;
        logic             error;
    } t_vector_row;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [WIDTH-1:0]     message = '0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_EXPONENT;
    logic [WIDTH-1:0]     cfg_data = '0;
    logic                 busy;
    logic                 valid;
    logic [WIDTH-1:0]     result;
    logic                 error;
    logic                 cfg_ready;

    logic [WIDTH-1:0] cur_exponent = WIDTH'(1);
    logic [WIDTH-1:0] cur_modulus = '0;
    t_power           pending_powers[$];
    int               mismatch_count = 0;

    t_vector_row vector_table[17] = '{
        '{CFG_KEEP, 32'h0,        32'h0,        32'hFFFF_FFFF, 1, 32'h0,         1'b1},
        '{CFG_MOD,  32'h0,        32'd1000,     32'd12345,     1, 32'd345,       1'b0},
        '{CFG_BOTH, 32'h0,        32'd1,        32'd7,         1, 32'd1,         1'b0},
        '{CFG_MOD,  32'h0,        32'hFFFF_FFFF, 32'h0,        1, 32'd1,         1'b0},
        '{CFG_BOTH, 32'hFFFF_FFFF, 32'h0,       32'd5,         1, 32'h0,         1'b1},
        '{CFG_BOTH, 32'd5,        32'd1,        32'd9,         1, 32'h0,         1'b0},
        '{CFG_BOTH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0,       1'b0},
        '{CFG_MOD,  32'h0,        32'hFFFF_FFFB, 32'hFFFF_FFFE, 0, 32'h0,        1'b0},
        '{CFG_BOTH, 32'd2,        32'hFFFF_FFFF, 32'hFFFF_FFFE, 1, 32'd1,        1'b0},
        '{CFG_BOTH, 32'd1,        32'd10,       32'h0,         1, 32'h0,         1'b0},
        '{CFG_BOTH, 32'd3,        32'd7,        32'd8,         1, 32'd1,         1'b0},
        '{CFG_BOTH, 32'd65537,    32'd3233,     32'd65,        0, 32'h0,         1'b0},
        '{CFG_BOTH, 32'h8000_0000, 32'h8000_0000, 32'd3,       0, 32'h0,         1'b0},
        '{CFG_BOTH, 32'd1,        32'hFFFF_FFFF, 32'hFFFF_FFFE, 1, 32'hFFFF_FFFE, 1'b0},
        '{CFG_BOTH, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678, 0, 32'h0,       1'b0},
        '{CFG_BOTH, 32'h0,        32'h0,        32'h0,         1, 32'h0,         1'b1},
        '{CFG_BOTH, 32'd2,        32'h8000_0001, 32'h8000_0000, 0, 32'h0,        1'b0}
    };

    int idle_by_phase[4] = '{0, 72, 0, 15};

    modular_exponentiation_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_message   (message),
        .o_valid     (valid),
        .o_result    (result),
        .o_error     (error),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic t_power predict_power(input logic [WIDTH-1:0] base);
        t_power           p;
        logic [2*WIDTH-1:0] acc;
        logic [2*WIDTH-1:0] sq;
        logic [2*WIDTH-1:0] modn;
        logic [WIDTH-1:0]   bits;
        modn = {{WIDTH{1'b0}}, cur_modulus};
        bits = cur_exponent;
        if (modn == '0) begin
            p.result = '0;
            p.error  = 1'b1;
            return p;
        end
        acc = (2*WIDTH)'(1);
        sq  = {{WIDTH{1'b0}}, base} % modn;
        while (bits != '0) begin
            if (bits[0]) begin
                acc = (acc * sq) % modn;
            end
            sq   = (sq * sq) % modn;
            bits = bits >> 1;
        end
        p.result = acc[WIDTH-1:0];
        p.error  = 1'b0;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [WIDTH-1:0] got,
                                   input logic [WIDTH-1:0] want);
        mismatch_count++;
        $display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    always @(posedge clk) begin
        t_power want;
        if (rst_n && valid) begin
            if (pending_powers.size() == 0) begin
                report_mismatch("unexpected result", result, '0);
            end else begin
                want = pending_powers.pop_front();
                if (result !== want.result) begin
                    report_mismatch("result", result, want.result);
                end
                if (error !== want.error) begin
                    report_mismatch("error", WIDTH'(error), WIDTH'(want.error));
                end
            end
        end
    end

    // Holds start low and waits until every outstanding item has produced its result.
    task automatic wait_idle();
        if (start) begin
            start <= 1'b0;
        end
        while (pending_powers.size() != 0 || busy) begin
            @(posedge clk);
        end
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH-1:0] data,
                            inout bit raised);
        if (!raised) begin
            cfg_valid <= 1'b1;
        end
        raised = 1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_config(input logic [1:0] mask, input logic [WIDTH-1:0] exp_val,
                                input logic [WIDTH-1:0] mod_val);
        bit raised;
        raised = 0;
        if (mask == CFG_KEEP) begin
            return;
        end
        wait_idle();
        if (mask[REG_EXPONENT]) begin
            cfg_beat(REG_EXPONENT, exp_val, raised);
            cur_exponent = exp_val;
        end
        if (mask[REG_MODULUS]) begin
            cfg_beat(REG_MODULUS, mod_val, raised);
            cur_modulus = mod_val;
        end
        cfg_valid <= 1'b0;
    endtask

    // Presents one item after a random gap and returns at the edge that accepts it,
    // with start still high so that a following item can go out without a gap.
    task automatic issue_message(input logic [WIDTH-1:0] msg, input t_power want,
                                 input int idle_pct);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        message <= msg;
        do @(posedge clk); while (busy);
        pending_powers.push_back(want);
    endtask

    function automatic logic [WIDTH-1:0] random_exponent();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            default: return $urandom_range(65535, 1);
        endcase
    endfunction

    function automatic logic [WIDTH-1:0] random_modulus();
        case ($urandom_range(9))
            0: return '0;
            1: return WIDTH'(1);
            2: return '1;
            3: return $urandom_range(255, 2);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WIDTH-1:0] random_message();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return $urandom_range(255, 0);
            3: return cur_modulus - WIDTH'(1);
            4: return cur_modulus;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_power           want;
        logic [WIDTH-1:0] msg;
        int               waited;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vector_table[i]) begin
            write_config(vector_table[i].cfg_mask, vector_table[i].exp_val,
                         vector_table[i].mod_val);
            if (vector_table[i].known) begin
                want.result = vector_table[i].result;
                want.error  = vector_table[i].error;
            end else begin
                want = predict_power(vector_table[i].msg);
            end
            issue_message(vector_table[i].msg, want, 0);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_config((p == 0) ? CFG_BOTH : 2'($urandom_range(3, 1)),
                         random_exponent(), random_modulus());
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(19) == 0) begin
                    wait_idle();
                end
                msg  = random_message();
                want = predict_power(msg);
                issue_message(msg, want, idle_by_phase[p % 4]);
            end
        end

        start <= 1'b0;
        waited = 0;
        while (pending_powers.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);
        if (pending_powers.size() != 0) begin
            report_mismatch("results never delivered", WIDTH'(pending_powers.size()), '0);
        end
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(40_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
